>>> rtl/iir_df1_pkg.sv
// Package for the direct-form-I IIR filter: sample, term and accumulator
// types, FSM states and configuration register indexes. No dependencies.
package iir_df1_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int COEF_FRAC  = 14;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 64;
    localparam int CNT_W      = 4;
    localparam int PSUM_W     = 21;
    localparam int ACC_W      = 36;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COEF_W-1:0]   t_coef;
    typedef logic signed [PSUM_W-1:0]   t_psum;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;
    typedef logic [CNT_W-1:0]           t_cnt;

    localparam t_cfg_idx REG_FF_LO  = 4'd0;
    localparam t_cfg_idx REG_FF_HI  = 4'd1;
    localparam t_cfg_idx REG_FB_LO  = 4'd2;
    localparam t_cfg_idx REG_FB_HI  = 4'd3;
    localparam t_cfg_idx REG_FF_CNT = 4'd4;
    localparam t_cfg_idx REG_FB_CNT = 4'd5;

    localparam logic [63:0] FF_LO_RESET = 64'd16384;
    localparam t_acc ROUND_HALF = t_acc'(1) <<< (COEF_FRAC - 1);
    localparam t_acc Q_MAX = t_acc'(32767);
    localparam t_acc Q_MIN = -t_acc'(32768);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } t_state;

endpackage

>>> rtl/iir_df1_ifs.sv
// Handshake interfaces of the IIR filter: input items, result items and
// configuration writes. Depends on iir_df1_pkg.
interface iir_df1_in_if import iir_df1_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_in;
    logic    new_block;
    modport source (output valid, output sample_in, output new_block, input ready);
    modport sink   (input valid, input sample_in, input new_block, output ready);
endinterface

interface iir_df1_out_if import iir_df1_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample sample_out;
    logic    saturated;
    modport source (output valid, output sample_out, output saturated, input ready);
    modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

interface iir_df1_cfg_if import iir_df1_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/iir_direct_form_one_filter.sv
// Direct-form-I IIR filter, Q2.14 coefficients, 16-bit samples, bit-serial.
// Depends on iir_df1_pkg and the interfaces in iir_df1_ifs.sv.
//
// One item passes through the accept state, a bit-serial phase and then one
// round/saturate state. The current sample and both histories sit in rotating
// shift registers that present one bit each per cycle, MSB first; one adder
// tree sums the gated coefficients of all taps and the accumulator doubles and
// adds each cycle, so the sample width sets the phase length. The result
// goes to an output register, so the next item is accepted while it waits; the
// final cycle of an item stalls only if the previous result is still held.
// Configuration writes are always taken and must arrive while the block idles.
module iir_direct_form_one_filter import iir_df1_pkg::*; #(
    parameter int MAX_FF_TAPS = 8,
    parameter int MAX_FB_TAPS = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iir_df1_cfg_if.sink   i_cfg,
    iir_df1_in_if.sink    i_in,
    iir_df1_out_if.source o_out
);

    localparam int FB_HIST = (MAX_FB_TAPS > 1) ? MAX_FB_TAPS - 1 : 1;

    logic [63:0] r_ff_lo, r_ff_hi, r_fb_lo;
    logic [47:0] r_fb_hi;
    t_cnt        r_ff_cnt, r_fb_cnt;

    t_state  r_state, n_state;
    t_cnt    r_bit;
    t_acc    r_acc, n_acc;
    t_sample r_xs [MAX_FF_TAPS];
    t_sample r_ys [FB_HIST];
    logic    r_out_valid;
    t_sample r_out_sample;
    logic    r_out_sat;

    logic [127:0] ff_coefs;
    logic [111:0] fb_coefs;
    t_cnt         ff_n, fb_n;
    t_psum        ff_sum, fb_sum, psum;
    t_acc         rnd, q;
    t_sample      y;
    logic         y_sat;
    logic         fin_go;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.saturated  = r_out_sat;

    assign ff_coefs = {r_ff_hi, r_ff_lo};
    assign fb_coefs = {r_fb_hi, r_fb_lo};
    assign ff_n = (r_ff_cnt > t_cnt'(MAX_FF_TAPS)) ? t_cnt'(MAX_FF_TAPS) : r_ff_cnt;
    assign fb_n = (r_fb_cnt > t_cnt'(MAX_FB_TAPS)) ? t_cnt'(MAX_FB_TAPS) : r_fb_cnt;

    // sum of coefficients whose sample bit is set; feedback enters negated
    always_comb begin
        ff_sum = '0;
        fb_sum = '0;
        for (int k = 0; k < MAX_FF_TAPS; k++) begin
            if (r_xs[k][SAMPLE_W-1] && (t_cnt'(k) < ff_n)) begin
                ff_sum = ff_sum + t_psum'(t_coef'(ff_coefs[COEF_W*k +: COEF_W]));
            end
        end
        for (int k = 1; k < MAX_FB_TAPS; k++) begin
            if (r_ys[k-1][SAMPLE_W-1] && (t_cnt'(k) < fb_n)) begin
                fb_sum = fb_sum - t_psum'(t_coef'(fb_coefs[COEF_W*(k-1) +: COEF_W]));
            end
        end
        psum = ff_sum + fb_sum;
    end

    // sign bit carries negative weight
    assign n_acc = (r_bit == t_cnt'(SAMPLE_W - 1)) ? -t_acc'(psum)
                                                   : (r_acc <<< 1) + t_acc'(psum);

    // round half up, floor shift, saturate
    always_comb begin
        rnd = r_acc + ROUND_HALF;
        q   = rnd >>> COEF_FRAC;
        if (q > Q_MAX) begin
            y     = t_sample'(Q_MAX);
            y_sat = 1'b1;
        end else if (q < Q_MIN) begin
            y     = t_sample'(Q_MIN);
            y_sat = 1'b1;
        end else begin
            y     = t_sample'(q);
            y_sat = 1'b0;
        end
    end

    assign fin_go = (r_state == ST_FIN) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in.valid) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (r_bit == '0) n_state = ST_FIN;
            end
            ST_FIN: begin
                if (fin_go) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff_lo  <= FF_LO_RESET;
            r_ff_hi  <= '0;
            r_fb_lo  <= '0;
            r_fb_hi  <= '0;
            r_ff_cnt <= t_cnt'(1);
            r_fb_cnt <= t_cnt'(1);
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_FF_LO:  r_ff_lo  <= i_cfg.data;
                REG_FF_HI:  r_ff_hi  <= i_cfg.data;
                REG_FB_LO:  r_fb_lo  <= i_cfg.data;
                REG_FB_HI:  r_fb_hi  <= i_cfg.data[47:0];
                REG_FF_CNT: r_ff_cnt <= i_cfg.data[CNT_W-1:0];
                REG_FB_CNT: r_fb_cnt <= i_cfg.data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit       <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < MAX_FF_TAPS; k++) r_xs[k] <= '0;
            for (int k = 0; k < FB_HIST; k++) r_ys[k] <= '0;
        end else begin
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_xs[0] <= i_in.sample_in;
                        r_bit   <= t_cnt'(SAMPLE_W - 1);
                        if (i_in.new_block) begin
                            for (int k = 1; k < MAX_FF_TAPS; k++) r_xs[k] <= '0;
                            for (int k = 0; k < FB_HIST; k++) r_ys[k] <= '0;
                        end
                    end
                end
                ST_RUN: begin
                    r_bit <= r_bit - t_cnt'(1);
                    for (int k = 0; k < MAX_FF_TAPS; k++)
                        r_xs[k] <= {r_xs[k][SAMPLE_W-2:0], r_xs[k][SAMPLE_W-1]};
                    for (int k = 0; k < FB_HIST; k++)
                        r_ys[k] <= {r_ys[k][SAMPLE_W-2:0], r_ys[k][SAMPLE_W-1]};
                end
                ST_FIN: begin
                    if (fin_go) begin
                        for (int k = MAX_FF_TAPS - 1; k > 0; k--) r_xs[k] <= r_xs[k-1];
                        for (int k = FB_HIST - 1; k > 0; k--) r_ys[k] <= r_ys[k-1];
                        r_ys[0] <= y;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_RUN) r_acc <= n_acc;
        if (fin_go) begin
            r_out_sample <= y;
            r_out_sat    <= y_sat;
        end
    end

endmodule

>>> rtl/iir_df1_chk.sv
// Port-level checker for the IIR filter and its bind to the top level.
// Depends on iir_df1_pkg and iir_direct_form_one_filter.
module iir_df1_chk import iir_df1_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_sample i_out_sample,
    input logic    i_out_sat
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_sample) && $stable(i_out_sat))
        else $error("result changed while stalled");

    // one item at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("item accepted while another is in flight");

    // clipped results sit at a rail
    a_sat_rail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_sat |->
            (i_out_sample == 16'sh7fff) || (i_out_sample == 16'sh8000))
        else $error("saturated flag without rail value");

endmodule

bind iir_direct_form_one_filter iir_df1_chk u_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample_out),
    .i_out_sat    (o_out.saturated)
);
